/* rtl/ahc_pkg.sv */
`timescale 1ns / 1ps

package ahc_pkg;

    // fixed field widths
    localparam int HUE_W   = 15;
    localparam int SAT_W   = 13;
    localparam int LIGHT_W = 9;
    localparam int BYTE_W  = 8;

    // fractional precision of hue and saturation
    localparam int HUE_FRAC_BITS = 6;
    localparam int SAT_FRAC_BITS = 12;

    // hue arithmetic constants, in degrees
    localparam int DEG_SECTOR = 60;
    localparam int DEG_TURN   = 360;

    // hue numerator before scaling stays below 360 * 255
    localparam int HUE_N_W = 17;
    // quotient bits: 360 * 2^frac needs 9 + frac bits
    localparam int HUE_Q   = 9 + HUE_FRAC_BITS;
    localparam int HUE_D_W = HUE_N_W + HUE_FRAC_BITS;
    // saturation quotient reaches 2^frac, so one extra bit
    localparam int SAT_Q   = SAT_FRAC_BITS + 1;
    localparam int SAT_D_W = BYTE_W + SAT_FRAC_BITS;

    // divider pipeline depth: one quotient bit per stage
    localparam int PIPE_STAGES = (HUE_Q > SAT_Q) ? HUE_Q : SAT_Q;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // classified item from the front
    typedef struct packed {
        logic [BYTE_W-1:0]  alpha;
        logic [LIGHT_W-1:0] lightness;
        logic [BYTE_W-1:0]  spread;
        logic [BYTE_W-1:0]  den;
        logic signed [11:0] sec_sum;
        logic               hue_zero;
        logic               sat_zero;
    } t_cls;

    // finished result item
    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [SAT_W-1:0]   sat;
        logic [LIGHT_W-1:0] lightness;
        logic [BYTE_W-1:0]  alpha;
    } t_res;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [BYTE_W:0] div_step(
        input logic [BYTE_W-1:0] rem,
        input logic              in_bit,
        input logic [BYTE_W-1:0] dvsr
    );
        logic [BYTE_W:0] cand;
        logic [BYTE_W:0] diff;
        cand = {rem, in_bit};
        diff = cand - {1'b0, dvsr};
        if (cand >= {1'b0, dvsr}) begin
            div_step = {1'b1, diff[BYTE_W-1:0]};
        end else begin
            div_step = {1'b0, cand[BYTE_W-1:0]};
        end
    endfunction

endpackage

/* rtl/ahc_front.sv */
`timescale 1ns / 1ps

module ahc_front (
    input  logic [31:0]       i_argb_word,
    output ahc_pkg::t_cls     o_cls
);
    import ahc_pkg::*;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    logic [BYTE_W-1:0]  ch_r;
    logic [BYTE_W-1:0]  ch_g;
    logic [BYTE_W-1:0]  ch_b;
    logic [BYTE_W-1:0]  hi;
    logic [BYTE_W-1:0]  lo;
    logic [BYTE_W-1:0]  spread;
    logic [LIGHT_W-1:0] sum;
    logic [LIGHT_W-1:0] sum_flip;
    t_sector            sector;
    logic signed [8:0]  diff;
    logic signed [11:0] base;

    // unpack channels
    assign ch_r = i_argb_word[23:16];
    assign ch_g = i_argb_word[15:8];
    assign ch_b = i_argb_word[7:0];

    // max and min of the three channels
    always_comb begin
        hi = (ch_r > ch_g) ? ch_r : ch_g;
        hi = (hi > ch_b) ? hi : ch_b;
        lo = (ch_r < ch_g) ? ch_r : ch_g;
        lo = (lo < ch_b) ? lo : ch_b;
    end

    assign spread   = hi - lo;
    assign sum      = {1'b0, hi} + {1'b0, lo};
    assign sum_flip = 9'd510 - sum;

    // hue sector by dominant channel: a red-green tie goes to green, green-blue to blue, red-blue to red
    always_comb begin
        if (hi == ch_r && hi != ch_g) begin
            sector = SEC_RED;
        end else if (hi == ch_g && hi != ch_b) begin
            sector = SEC_GREEN;
        end else begin
            sector = SEC_BLUE;
        end
    end

    // signed channel difference and sector offset in units of spread
    always_comb begin
        case (sector)
            SEC_RED: begin
                diff = $signed({1'b0, ch_g}) - $signed({1'b0, ch_b});
                base = '0;
            end
            SEC_GREEN: begin
                diff = $signed({1'b0, ch_b}) - $signed({1'b0, ch_r});
                base = $signed({3'b000, spread, 1'b0});
            end
            default: begin
                diff = $signed({1'b0, ch_r}) - $signed({1'b0, ch_g});
                base = $signed({2'b00, spread, 2'b00});
            end
        endcase
    end

    // classified item
    always_comb begin
        o_cls.alpha     = i_argb_word[31:24];
        o_cls.lightness = sum;
        o_cls.spread    = spread;
        o_cls.den       = (sum < 9'd255) ? sum[BYTE_W-1:0] : sum_flip[BYTE_W-1:0];
        o_cls.sec_sum   = base + 12'(diff);
        o_cls.hue_zero  = (spread == '0);
        o_cls.sat_zero  = (spread == '0) || (sum == '0) || (sum == 9'd510);
    end

endmodule

/* rtl/ahc_queue.sv */
`timescale 1ns / 1ps

module ahc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  ahc_pkg::t_cls  i_data,
    output logic           o_full,
    input  logic           i_rd,
    output ahc_pkg::t_cls  o_data,
    output logic           o_empty
);
    import ahc_pkg::*;

    t_cls            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_rd |-> !i_wr)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_rd)
        else $error("queue read while empty");

endmodule

/* rtl/ahc_back.sv */
`timescale 1ns / 1ps

module ahc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ahc_pkg::t_cls  i_cls,
    input  logic           i_cls_vld,
    output logic           o_cls_rd,
    output ahc_pkg::t_res  o_res,
    output logic           o_empty,
    input  logic           i_pop
);
    import ahc_pkg::*;

    localparam int NS = PIPE_STAGES;

    // divider pipeline registers, stage 0 is the loaded operand stage
    logic                 r_vld  [NS+1];
    logic [BYTE_W-1:0]    r_hrem [NS+1];
    logic [HUE_Q-1:0]     r_hsr  [NS+1];
    logic [BYTE_W-1:0]    r_srem [NS+1];
    logic [SAT_Q-1:0]     r_ssr  [NS+1];
    logic [BYTE_W-1:0]    r_hdv  [NS+1];
    logic [BYTE_W-1:0]    r_sdv  [NS+1];
    logic                 r_hz   [NS+1];
    logic                 r_sz   [NS+1];
    logic [LIGHT_W-1:0]   r_lt   [NS+1];
    logic [BYTE_W-1:0]    r_al   [NS+1];

    // output buffer
    t_res                 r_obuf [2];
    logic                 r_owp;
    logic                 r_orp;
    logic [1:0]           r_ocnt;

    logic                 adv;
    logic                 out_push;
    logic                 out_pop;
    logic                 out_full;

    logic signed [18:0]   n60;
    logic [HUE_N_W-1:0]   full_turn;
    logic signed [18:0]   n_wrap;
    logic [HUE_D_W-1:0]   hue_dvd;
    logic [SAT_D_W-1:0]   sat_dvd;
    logic [31:0]          hue_wide;
    logic [31:0]          sat_wide;
    t_res                 fin;

    // whole pipeline moves unless the last stage is blocked by the buffer
    assign out_full = (r_ocnt == 2'd2);
    assign adv      = !(r_vld[NS] && out_full);
    assign o_cls_rd = adv && i_cls_vld;
    assign out_push = adv && r_vld[NS];
    assign out_pop  = i_pop && (r_ocnt != 2'd0);

    // hue numerator: 60 degrees times sector sum, wrapped into one turn
    always_comb begin
        n60       = 19'(i_cls.sec_sum) * 19'sd60;
        full_turn = HUE_N_W'(i_cls.spread) * HUE_N_W'(DEG_TURN);
        n_wrap    = (n60 < 0) ? n60 + $signed({2'b00, full_turn}) : n60;
        hue_dvd   = HUE_D_W'(n_wrap[HUE_N_W-1:0]) << HUE_FRAC_BITS;
        sat_dvd   = SAT_D_W'(i_cls.spread) << SAT_FRAC_BITS;
    end

    // operand stage
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hrem[0] <= hue_dvd[HUE_D_W-1 -: BYTE_W];
            r_hsr[0]  <= hue_dvd[HUE_Q-1:0];
            r_srem[0] <= BYTE_W'(sat_dvd[SAT_D_W-1:SAT_Q]);
            r_ssr[0]  <= sat_dvd[SAT_Q-1:0];
            r_hdv[0]  <= i_cls.spread;
            r_sdv[0]  <= i_cls.den;
            r_hz[0]   <= i_cls.hue_zero;
            r_sz[0]   <= i_cls.sat_zero;
            r_lt[0]   <= i_cls.lightness;
            r_al[0]   <= i_cls.alpha;
        end
    end

    // one quotient bit per stage for each divider, until that divider's quotient is full
    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [BYTE_W:0] h_step;
        logic [BYTE_W:0] s_step;

        assign h_step = div_step(r_hrem[s], r_hsr[s][HUE_Q-1], r_hdv[s]);
        assign s_step = div_step(r_srem[s], r_ssr[s][SAT_Q-1], r_sdv[s]);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (s < HUE_Q) begin
                    r_hrem[s+1] <= h_step[BYTE_W-1:0];
                    r_hsr[s+1]  <= {r_hsr[s][HUE_Q-2:0], h_step[BYTE_W]};
                end else begin
                    r_hrem[s+1] <= r_hrem[s];
                    r_hsr[s+1]  <= r_hsr[s];
                end
                if (s < SAT_Q) begin
                    r_srem[s+1] <= s_step[BYTE_W-1:0];
                    r_ssr[s+1]  <= {r_ssr[s][SAT_Q-2:0], s_step[BYTE_W]};
                end else begin
                    r_srem[s+1] <= r_srem[s];
                    r_ssr[s+1]  <= r_ssr[s];
                end
                r_hdv[s+1] <= r_hdv[s];
                r_sdv[s+1] <= r_sdv[s];
                r_hz[s+1]  <= r_hz[s];
                r_sz[s+1]  <= r_sz[s];
                r_lt[s+1]  <= r_lt[s];
                r_al[s+1]  <= r_al[s];
            end
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_cls_vld;
            for (int k = 0; k < NS; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    // final result: hue zero for grey, saturation zero for grey and for the lightness ends
    always_comb begin
        hue_wide      = 32'(r_hsr[NS]);
        sat_wide      = 32'(r_ssr[NS]);
        fin.hue       = r_hz[NS] ? '0 : hue_wide[HUE_W-1:0];
        fin.sat       = r_sz[NS] ? '0 : sat_wide[SAT_W-1:0];
        fin.lightness = r_lt[NS];
        fin.alpha     = r_al[NS];
    end

    // two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_obuf[r_owp] <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (out_push) begin
                r_owp <= ~r_owp;
            end
            if (out_pop) begin
                r_orp <= ~r_orp;
            end
            case ({out_push, out_pop})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    assign o_res   = r_obuf[r_orp];
    assign o_empty = (r_ocnt == 2'd0);

    a_obuf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2)
        else $error("output buffer count beyond two");
    a_tail_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS] && out_full |=> r_vld[NS])
        else $error("blocked item dropped from last stage");
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS] && !r_sz[NS] |-> sat_wide <= (32'd1 << SAT_FRAC_BITS))
        else $error("saturation quotient above one");

endmodule

/* rtl/argb_to_hsl_convert.sv */
`timescale 1ns / 1ps
// a result passes the queue, the operand stage, 15 divider stages and the output buffer
// throughput: one item per cycle while the output buffer has room, one quotient bit a stage
// a 4-entry queue parts the classify front from the divider back
// a 2-entry output buffer lets the input keep flowing while a result waits
// reset: synchronous active-low i_rst_n empties both queues and the pipeline

module argb_to_hsl_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_argb_word,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [14:0] o_hue,
    output logic [12:0] o_saturation,
    output logic [8:0]  o_lightness,
    output logic [7:0]  o_alpha
);
    import ahc_pkg::*;

    t_cls cls_in;
    t_cls cls_head;
    logic q_full;
    logic q_empty;
    logic q_rd;
    logic q_wr;
    t_res res;

    // classify front
    ahc_front u_front (
        .i_argb_word (i_argb_word),
        .o_cls       (cls_in)
    );

    assign q_wr   = i_push && !q_full;
    assign o_full = q_full;

    // decoupling queue
    ahc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (cls_in),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_data  (cls_head),
        .o_empty (q_empty)
    );

    // divider back end with output buffer
    ahc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cls     (cls_head),
        .i_cls_vld (!q_empty),
        .o_cls_rd  (q_rd),
        .o_res     (res),
        .o_empty   (o_empty),
        .i_pop     (i_pop)
    );

    assign o_hue        = res.hue;
    assign o_saturation = res.sat;
    assign o_lightness  = res.lightness;
    assign o_alpha      = res.alpha;

endmodule

/* sim/tb_argb_to_hsl_convert.sv */
`timescale 1ns / 1ps

module tb_argb_to_hsl_convert;
    import ahc_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 7;
    localparam int IDLE_PCT        = 32;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int MAX_REPORTS     = 10;
    localparam int HOLD_OFF_CYCLES = 250;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [31:0] i_argb_word;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic [14:0] o_hue;
    logic [12:0] o_saturation;
    logic [8:0]  o_lightness;
    logic [7:0]  o_alpha;

    // keeps predicted hsl values for pixels taken by the block, oldest first
    class hsl_scoreboard;
        t_res expected_hsl[$];
        int   mismatches;

        // exact integer hsl of one packed argb pixel
        function t_res predict_hsl(logic [31:0] w);
            t_res   res;
            int     r;
            int     g;
            int     b;
            int     hi;
            int     lo;
            int     spread;
            int     sum;
            int     den;
            longint n;
            longint sat_q;
            longint hue_q;
            r      = int'(w[23:16]);
            g      = int'(w[15:8]);
            b      = int'(w[7:0]);
            hi     = (r > g) ? r : g;
            hi     = (hi > b) ? hi : b;
            lo     = (r < g) ? r : g;
            lo     = (lo < b) ? lo : b;
            spread = hi - lo;
            sum    = hi + lo;
            sat_q  = 0;
            hue_q  = 0;
            // zero saturation for grey, black and white
            if (spread > 0 && sum > 0 && sum < 510) begin
                den   = (sum < 255) ? sum : 510 - sum;
                sat_q = (longint'(spread) << SAT_FRAC_BITS) / longint'(den);
            end
            // sector pick follows the max channel, ties fall through
            if (spread > 0) begin
                if (hi == r && hi != g) begin
                    n = longint'(g - b);
                end else if (hi == g && hi != b) begin
                    n = longint'(2 * spread + b - r);
                end else begin
                    n = longint'(4 * spread + r - g);
                end
                n = n * longint'(DEG_SECTOR);
                if (n < 0) begin
                    n = n + longint'(DEG_TURN * spread);
                end
                hue_q = (n << HUE_FRAC_BITS) / longint'(spread);
            end
            res.hue       = hue_q[HUE_W-1:0];
            res.sat       = sat_q[SAT_W-1:0];
            res.lightness = sum[LIGHT_W-1:0];
            res.alpha     = w[31:24];
            return res;
        endfunction

        function void note_pixel(logic [31:0] w);
            expected_hsl.push_back(predict_hsl(w));
        endfunction

        function void check_result(t_res got);
            t_res exp_res;
            if (expected_hsl.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result with no pixel pending: hue %0d sat %0d light %0d a %0d",
                             $time, got.hue, got.sat, got.lightness, got.alpha);
                end
                return;
            end
            exp_res = expected_hsl.pop_front();
            if (got.hue !== exp_res.hue || got.sat !== exp_res.sat ||
                got.lightness !== exp_res.lightness || got.alpha !== exp_res.alpha) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: mismatch exp hue %0d sat %0d light %0d a %0d", $time,
                             exp_res.hue, exp_res.sat, exp_res.lightness, exp_res.alpha);
                    $display("%0t:          got hue %0d sat %0d light %0d a %0d", $time,
                             got.hue, got.sat, got.lightness, got.alpha);
                end
            end
        endfunction

        function int pending();
            return expected_hsl.size();
        endfunction
    endclass

    hsl_scoreboard sb;
    int   send_idle_pct;
    int   pop_idle_pct;
    logic hold_off_req = 1'b0;
    int   cycle_count = 0;

    // grey, black, white, primaries, ties, sum edges and negative hue
    logic [31:0] corner_pixels [0:23] = '{
        32'h00000000, 32'hFFFFFFFF, 32'h80808080, 32'hFF000000,
        32'h00FFFFFF, 32'h7FFF0000, 32'h0000FF00, 32'h000000FF,
        32'h00FFFF00, 32'h0000FFFF, 32'h00FF00FF, 32'h00FE0000,
        32'h00FF0100, 32'h00010000, 32'h00FFFFFE, 32'h00FF1020,
        32'h00102030, 32'h00302010, 32'h00201030, 32'hA5123456,
        32'h5A654321, 32'h00FEFFFE, 32'h00010101, 32'h00000100
    };

    argb_to_hsl_convert dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_argb_word  (i_argb_word),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_lightness  (o_lightness),
        .o_alpha      (o_alpha)
    );

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // watch both handshakes at the rising edge
    always @(posedge i_clk) begin
        t_res got;
        got.hue       = o_hue;
        got.sat       = o_saturation;
        got.lightness = o_lightness;
        got.alpha     = o_alpha;
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                sb.note_pixel(i_argb_word);
            end
            if (i_pop && !o_empty) begin
                sb.check_result(got);
            end
        end
    end

    // result side: random stalls, plus a counted hold-off when requested
    initial begin
        logic hold_off_seen;
        int   hold_off_left;
        hold_off_seen = 1'b0;
        hold_off_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req != hold_off_seen) begin
                hold_off_seen = hold_off_req;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                hold_off_left = hold_off_left - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(99) >= pop_idle_pct);
            end
        end
    end

    // offer one pixel, with random idle cycles ahead of it
    task automatic send_pixel(logic [31:0] w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push      <= 1'b1;
        i_argb_word <= w;
        do @(posedge i_clk); while (o_full);
    endtask

    // mostly full-range words, the rest grey or with channels at the rails
    task automatic send_random_pixels(int count);
        logic [31:0] w;
        logic [7:0]  ch [3];
        for (int i = 0; i < count; i++) begin
            w = $urandom;
            case ($urandom_range(9))
                0, 1: begin
                    w[15:8] = w[23:16];
                    w[7:0]  = w[23:16];
                end
                2, 3: begin
                    foreach (ch[k]) begin
                        case ($urandom_range(3))
                            0:       ch[k] = 8'h00;
                            1:       ch[k] = 8'hFF;
                            2:       ch[k] = w[23:16];
                            default: ch[k] = 8'($urandom_range(255));
                        endcase
                    end
                    w[23:0] = {ch[0], ch[1], ch[2]};
                end
                default: ;
            endcase
            send_pixel(w);
        end
    endtask

    // stop offering and wait for every predicted result
    task automatic drain_results();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb              = new();
        i_rst_n         = 1'b0;
        i_push          = 1'b0;
        i_argb_word     = '0;
        send_idle_pct   = IDLE_PCT;
        pop_idle_pct    = IDLE_PCT;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        foreach (corner_pixels[i]) begin
            send_pixel(corner_pixels[i]);
        end
        drain_results();

        send_random_pixels(600);

        // receiver holds off while the sender keeps pushing, block fills
        hold_off_req  = ~hold_off_req;
        send_idle_pct = 0;
        send_random_pixels(150);

        // stretch with no idling on either side
        pop_idle_pct = 0;
        send_random_pixels(400);
        send_idle_pct = IDLE_PCT;
        pop_idle_pct  = IDLE_PCT;

        // sender pauses until everything is back
        drain_results();
        send_random_pixels(750);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
